FILE: src/marching_squares_contour_points_top_assert.svh
// Assertion macros for the checker file of this block.
`ifndef MARCHING_SQUARES_CONTOUR_POINTS_TOP_ASSERT_SVH
`define MARCHING_SQUARES_CONTOUR_POINTS_TOP_ASSERT_SVH

// Assertion that is switched off while reset is held.
`define MSQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked across reset.
`define MSQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/msq_pkg.sv
// ----------------------------------------------------------------------------
// msq_pkg
// Types, codes and case tables of the marching squares contour point block.
// ----------------------------------------------------------------------------
package msq_pkg;

  // One grid node: value and position, all signed Q8.8.
  typedef struct packed {
    logic signed [15:0] v;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } node_t;

  // Cell edges.
  typedef enum logic [1:0] {
    EDGE_TOP    = 2'd0,
    EDGE_RIGHT  = 2'd1,
    EDGE_BOTTOM = 2'd2,
    EDGE_LEFT   = 2'd3
  } edge_t;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_ISOLEVEL    = 2'd0;
  localparam logic [1:0] REG_INTERPOLATE = 2'd1;
  localparam logic [1:0] REG_GRID_SIZE   = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EDGE,
    ST_DIV,
    ST_MID,
    ST_MUL,
    ST_ADD,
    ST_OUT
  } msq_state_t;

  // Number of crossed edges for a cell code.
  function automatic logic [2:0] edge_cnt(input logic [3:0] code);
    logic [2:0] n;
    case (code)
      4'd0, 4'd15: n = 3'd0;
      4'd5, 4'd10: n = 3'd4;
      default:     n = 3'd2;
    endcase
    return n;
  endfunction

  // Edge emitted at position k for a cell code.
  function automatic edge_t edge_of(input logic [3:0] code, input logic [1:0] k);
    edge_t e;
    e = EDGE_TOP;
    case (code)
      4'd1, 4'd14: e = (k == 2'd0) ? EDGE_LEFT : EDGE_BOTTOM;
      4'd2, 4'd13: e = (k == 2'd0) ? EDGE_RIGHT : EDGE_BOTTOM;
      4'd3, 4'd12: e = (k == 2'd0) ? EDGE_LEFT : EDGE_RIGHT;
      4'd4, 4'd11: e = (k == 2'd0) ? EDGE_TOP : EDGE_RIGHT;
      4'd6, 4'd9:  e = (k == 2'd0) ? EDGE_TOP : EDGE_BOTTOM;
      4'd7:        e = (k == 2'd0) ? EDGE_LEFT : EDGE_TOP;
      4'd8:        e = (k == 2'd0) ? EDGE_TOP : EDGE_LEFT;
      4'd5: begin
        case (k)
          2'd0:    e = EDGE_LEFT;
          2'd1:    e = EDGE_TOP;
          2'd2:    e = EDGE_BOTTOM;
          default: e = EDGE_RIGHT;
        endcase
      end
      4'd10: begin
        case (k)
          2'd0:    e = EDGE_LEFT;
          2'd1:    e = EDGE_BOTTOM;
          2'd2:    e = EDGE_TOP;
          default: e = EDGE_RIGHT;
        endcase
      end
      default: e = EDGE_TOP;
    endcase
    return e;
  endfunction

endpackage

FILE: src/msq_div.sv
// ----------------------------------------------------------------------------
// msq_div
// Restoring divider giving the Q0.16 fraction num/den, one bit per cycle.
// ----------------------------------------------------------------------------
module msq_div
  import msq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [15:0] quot
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] den_r, den_nxt;
  logic [15:0] q_r, q_nxt;
  logic [16:0] rem_sh;

  // One quotient bit per cycle; the remainder stays below the divisor.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    rem_sh   = {rem_r[15:0], 1'b0};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      rem_nxt  = {1'b0, num};
      den_nxt  = den;
      q_nxt    = 16'd0;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt = rem_sh - {1'b0, den_r};
        q_nxt   = {q_r[14:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: src/msq_lbuf.sv
// ----------------------------------------------------------------------------
// msq_lbuf
// Line store holding the previous row of nodes, with a registered read port.
// ----------------------------------------------------------------------------
module msq_lbuf
  import msq_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
)
(
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output node_t         rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  node_t         wr_data
);

  node_t mem [DEPTH];
  node_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/marching_squares_contour_points_top.sv
// ----------------------------------------------------------------------------
// marching_squares_contour_points_top
// Marching squares isoline point generator over a raster-ordered grid.
// ----------------------------------------------------------------------------
// Usage: grid samples enter on the in_ channel (in_valid / in_stall) in
// raster order. Each sample from row 1, column 1 onward closes one cell,
// and the block sends 0, 2 or 4 contour points for it on the out_ channel
// (out_valid / out_stall), out_last_point marking the cell's final point.
// One item is worked on at a time: in_stall is high from the cycle after
// acceptance until the cell's last point has been taken.
// A cell with no points is done once it is loaded. Each point passes through
// the edge, midpoint and output states in midpoint mode, or through the edge,
// divide, multiply, add and output states when interpolating, the divide
// state using the single shared 16-step divider. While out_stall is high the
// current point holds and no new item enters. Reset clears the raster
// position, the saved left and upper-left nodes and registers (isolevel 0,
// interpolate 1, grid_size 256); the line store is not cleared, as the first
// row writes it before any cell reads it. Registers are to be written over
// the APB-style port only while the block idles; this is not enforced.
// ----------------------------------------------------------------------------
module marching_squares_contour_points_top
  import msq_pkg::*;
#(
  parameter int MAX_GRID = 256
)
(
  input  logic               clk,
  input  logic               rst_n,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Sample input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_sample_value,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  // Point output
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_point_x,
  output logic signed [15:0] out_point_y,
  output logic               out_last_point
);

  localparam int CW = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
  localparam int GW = (CW + 1 > 9) ? CW + 1 : 9;

  // Configuration registers
  logic signed [15:0] isolevel_r;
  logic               interp_r;
  logic [8:0]         grid_size_r;

  // Sequencer and raster state
  msq_state_t         state_r, state_nxt;
  logic [CW-1:0]      col_r, row_r;
  logic               emit_r;
  node_t              left_r, ul_r;
  node_t              nw_r, ne_r, se_r, sw_r;
  logic [3:0]         code_r;
  logic [2:0]         cnt_r;
  logic [1:0]         k_r;

  // Edge datapath
  logic signed [15:0] pa_r, pb_r, fix_r;
  logic               horiz_r;
  logic signed [15:0] prod_r;
  logic signed [15:0] res_x_r, res_y_r;
  logic               last_r, out_valid_r;

  // Control outputs of the sequencer
  logic               accept, mem_rd, mem_we, div_start;
  node_t              rd_node;
  logic               div_done;
  logic [15:0]        div_q;

  // Configuration write and read
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      isolevel_r  <= 16'sd0;
      interp_r    <= 1'b1;
      grid_size_r <= 9'd256;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ISOLEVEL:    isolevel_r  <= pwdata[15:0];
        REG_INTERPOLATE: interp_r    <= pwdata[0];
        REG_GRID_SIZE:   grid_size_r <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ISOLEVEL:    prdata = {{16{isolevel_r[15]}}, isolevel_r};
      REG_INTERPOLATE: prdata = {31'd0, interp_r};
      REG_GRID_SIZE:   prdata = {23'd0, grid_size_r};
      default:         prdata = 32'd0;
    endcase
  end

  // Effective grid size, clamped to the supported range.
  logic [GW-1:0] gs_ext, size_eff;
  always_comb begin
    gs_ext = GW'(grid_size_r);
    if (gs_ext < GW'(2)) begin
      size_eff = GW'(2);
    end else if (gs_ext > GW'(MAX_GRID)) begin
      size_eff = GW'(MAX_GRID);
    end else begin
      size_eff = gs_ext;
    end
  end

  // Line store
  msq_lbuf #(
    .DEPTH (MAX_GRID),
    .AW    (CW)
  ) u_lbuf (
    .clk     (clk),
    .rd_en   (mem_rd),
    .rd_addr (col_r),
    .rd_data (rd_node),
    .wr_en   (mem_we),
    .wr_addr (col_r),
    .wr_data (se_r)
  );

  // Shared divider
  logic [15:0] div_num, div_den;
  msq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_q)
  );

  // Cell code from the four corners as the cell closes.
  logic [3:0] code_now;
  assign code_now = {($signed(nw_r.v) >= isolevel_r),
                     ($signed(rd_node.v) >= isolevel_r),
                     ($signed(se_r.v) >= isolevel_r),
                     ($signed(sw_r.v) >= isolevel_r)};

  // Edge selection: active end a, inactive end b.
  edge_t e_cur;
  node_t p_n, q_n, a_n, b_n;
  logic  e_horiz;
  always_comb begin
    e_cur = edge_of(code_r, k_r);
    case (e_cur)
      EDGE_TOP:    begin p_n = nw_r; q_n = ne_r; e_horiz = 1'b1; end
      EDGE_RIGHT:  begin p_n = ne_r; q_n = se_r; e_horiz = 1'b0; end
      EDGE_BOTTOM: begin p_n = se_r; q_n = sw_r; e_horiz = 1'b1; end
      default:     begin p_n = nw_r; q_n = sw_r; e_horiz = 1'b0; end
    endcase
    if ($signed(p_n.v) >= isolevel_r) begin
      a_n = p_n;
      b_n = q_n;
    end else begin
      a_n = q_n;
      b_n = p_n;
    end
  end

  // t = (va - iso) / (va - vb); both differences fit 16 unsigned bits.
  logic signed [16:0] num_w, den_w;
  assign num_w   = 17'(a_n.v) - 17'(isolevel_r);
  assign den_w   = 17'(a_n.v) - 17'(b_n.v);
  assign div_num = num_w[15:0];
  assign div_den = den_w[15:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_LOAD;
      ST_LOAD: begin
        if (emit_r && edge_cnt(code_now) != 3'd0) begin
          state_nxt = ST_EDGE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EDGE: state_nxt = interp_r ? ST_DIV : ST_MID;
      ST_DIV:  if (div_done) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_OUT;
      ST_MID:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = (3'(k_r) + 3'd1 == cnt_r) ? ST_IDLE : ST_EDGE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    accept    = 1'b0;
    mem_rd    = 1'b0;
    mem_we    = 1'b0;
    div_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        accept = in_valid;
        mem_rd = in_valid;
      end
      ST_LOAD: mem_we = 1'b1;
      ST_EDGE: div_start = interp_r;
      default: ;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Raster position and corner nodes
  logic [GW-1:0] col_inc, row_inc;
  assign col_inc = GW'(col_r) + GW'(1);
  assign row_inc = GW'(row_r) + GW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      left_r <= '0;
      ul_r   <= '0;
      emit_r <= 1'b0;
    end else begin
      if (accept) begin
        emit_r <= (row_r != '0) && (col_r != '0);
      end
      if (state_r == ST_LOAD) begin
        ul_r   <= rd_node;
        left_r <= se_r;
        if (col_inc >= size_eff) begin
          col_r <= '0;
          row_r <= (row_inc >= size_eff) ? '0 : row_inc[CW-1:0];
        end else begin
          col_r <= col_inc[CW-1:0];
        end
      end
    end
  end

  // Cell capture
  always_ff @(posedge clk) begin
    if (accept) begin
      se_r <= '{v: in_sample_value, x: in_pos_x, y: in_pos_y};
      nw_r <= ul_r;
      sw_r <= left_r;
    end
    if (state_r == ST_LOAD) begin
      ne_r   <= rd_node;
      code_r <= code_now;
      cnt_r  <= edge_cnt(code_now);
    end
  end

  // Point index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= 2'd0;
    end else if (state_r == ST_LOAD) begin
      k_r <= 2'd0;
    end else if (state_r == ST_OUT && !out_stall) begin
      k_r <= k_r + 2'd1;
    end
  end

  // Edge datapath: midpoint, or active end plus t times the edge span.
  logic signed [16:0] mid_sum, span;
  logic signed [33:0] product;
  logic signed [15:0] mid_res, lerp_res;
  assign mid_sum  = 17'(pa_r) + 17'(pb_r);
  assign mid_res  = mid_sum[16:1];
  assign span     = 17'(pb_r) - 17'(pa_r);
  assign product  = $signed({1'b0, div_q}) * span;
  assign lerp_res = pa_r + prod_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_EDGE) begin
      horiz_r <= e_horiz;
      pa_r    <= e_horiz ? a_n.x : a_n.y;
      pb_r    <= e_horiz ? b_n.x : b_n.y;
      fix_r   <= e_horiz ? a_n.y : a_n.x;
      last_r  <= (3'(k_r) + 3'd1 == cnt_r);
    end
    if (state_r == ST_DIV && div_done) begin
      prod_r <= product[31:16];
    end
    if (state_r == ST_MID || state_r == ST_ADD) begin
      res_x_r <= horiz_r ? ((state_r == ST_MID) ? mid_res : lerp_res) : fix_r;
      res_y_r <= horiz_r ? fix_r : ((state_r == ST_MID) ? mid_res : lerp_res);
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_MID || state_r == ST_ADD) begin
      out_valid_r <= 1'b1;
    end else if (state_r == ST_OUT && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_point_x    = res_x_r;
  assign out_point_y    = res_y_r;
  assign out_last_point = last_r;

endmodule

FILE: src/msq_chk.sv
// ----------------------------------------------------------------------------
// msq_chk
// Port-level checker for the marching squares contour point block.
// ----------------------------------------------------------------------------
`include "marching_squares_contour_points_top_assert.svh"

module msq_chk
  import msq_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_point_x,
  input logic [15:0] out_point_y,
  input logic        out_last_point
);

  // A stalled point stays offered.
  `MSQ_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "point dropped under stall")

  // A stalled point keeps its payload.
  `MSQ_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_point_x) && $stable(out_point_y) && $stable(out_last_point), "stalled point changed")

  // No new item is taken while a point is pending.
  `MSQ_ASSERT(a_busy_out, out_valid |-> in_stall, "item accepted while point pending")

  // In the cycle after an item is accepted, no point is offered and the input stalls.
  `MSQ_ASSERT(a_acc_gap, in_valid && !in_stall |=> !out_valid && in_stall, "point too soon after item")

  // Reset leaves no point pending.
  `MSQ_ASSERT_RST(a_rst_out, !rst_n |=> !out_valid, "point pending after reset")

endmodule

bind marching_squares_contour_points_top msq_chk u_msq_chk (.*);

FILE: dv/msq_point_checker.sv
// ----------------------------------------------------------------------------
// msq_point_checker
// Watches the register port and both channels of the marching squares block,
// predicts the contour points of every accepted sample and compares each
// accepted point with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module msq_point_checker
  import msq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_sample_value,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_point_x,
  input  logic signed [15:0] out_point_y,
  input  logic               out_last_point,
  output int                 fail_count,
  output int                 points_due,
  output int                 points_checked,
  output int                 cells_closed
);

  typedef struct {
    int v;
    int x;
    int y;
  } grid_node_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
  } contour_point_t;

  contour_point_t     points_q[$];
  grid_node_t         prev_row[256];
  grid_node_t         west;
  grid_node_t         north_west;
  int                 col_pos;
  int                 row_pos;
  logic signed [15:0] iso;
  logic               interp;
  logic [8:0]         gsize;

  // A corner counts as inside the contour when it reaches the threshold.
  function automatic bit is_active(grid_node_t n);
    int lvl;
    lvl = iso;
    return n.v >= lvl;
  endfunction

  // Coordinate on an edge running from the active end a to the inactive end b.
  function automatic int along_edge(int pa, int pb, int va, int vb);
    longint num;
    longint den;
    longint t;
    longint prod;
    int     lvl;
    lvl = iso;
    if (!interp) return (pa + pb) >>> 1;
    num = longint'(va) - lvl;
    den = longint'(va) - vb;
    t = 0;
    if (den > 0 && num > 0) begin
      t = (num * 65536) / den;
      if (t > 65535) t = 65535;
    end
    prod = t * (longint'(pb) - pa);
    return pa + int'(prod >>> 16);
  endfunction

  function automatic int crossing_count(logic [3:0] code);
    if (code == 4'd0 || code == 4'd15) return 0;
    if (code == 4'd5 || code == 4'd10) return 4;
    return 2;
  endfunction

  // Order in which the crossed edges of a cell are reported.
  function automatic edge_t crossing(logic [3:0] code, int k);
    edge_t seq[4];
    seq = '{EDGE_TOP, EDGE_TOP, EDGE_TOP, EDGE_TOP};
    case (code)
      4'd1, 4'd14: seq = '{EDGE_LEFT, EDGE_BOTTOM, EDGE_TOP, EDGE_TOP};
      4'd2, 4'd13: seq = '{EDGE_RIGHT, EDGE_BOTTOM, EDGE_TOP, EDGE_TOP};
      4'd3, 4'd12: seq = '{EDGE_LEFT, EDGE_RIGHT, EDGE_TOP, EDGE_TOP};
      4'd4, 4'd11: seq = '{EDGE_TOP, EDGE_RIGHT, EDGE_TOP, EDGE_TOP};
      4'd6, 4'd9:  seq = '{EDGE_TOP, EDGE_BOTTOM, EDGE_TOP, EDGE_TOP};
      4'd7:        seq = '{EDGE_LEFT, EDGE_TOP, EDGE_TOP, EDGE_TOP};
      4'd8:        seq = '{EDGE_TOP, EDGE_LEFT, EDGE_TOP, EDGE_TOP};
      4'd5:        seq = '{EDGE_LEFT, EDGE_TOP, EDGE_BOTTOM, EDGE_RIGHT};
      4'd10:       seq = '{EDGE_LEFT, EDGE_BOTTOM, EDGE_TOP, EDGE_RIGHT};
      default:     seq = '{EDGE_TOP, EDGE_TOP, EDGE_TOP, EDGE_TOP};
    endcase
    return seq[k];
  endfunction

  // Close the cell ending at this sample, queue its points, advance the raster.
  task automatic predict_cell(grid_node_t se);
    grid_node_t     ne;
    grid_node_t     p;
    grid_node_t     q;
    grid_node_t     a;
    grid_node_t     b;
    logic [3:0]     code;
    int             eff;
    int             n;
    edge_t          e;
    contour_point_t pt;
    eff = (gsize < 2) ? 2 : (gsize > 256) ? 256 : int'(gsize);
    ne = prev_row[col_pos];
    if (row_pos >= 1 && col_pos >= 1) begin
      code = {is_active(north_west), is_active(ne), is_active(se), is_active(west)};
      n = crossing_count(code);
      if (n > 0) cells_closed++;
      for (int k = 0; k < n; k++) begin
        e = crossing(code, k);
        case (e)
          EDGE_TOP:    begin p = north_west; q = ne;   end
          EDGE_RIGHT:  begin p = ne;         q = se;   end
          EDGE_BOTTOM: begin p = se;         q = west; end
          default:     begin p = north_west; q = west; end
        endcase
        if (is_active(p)) begin
          a = p;
          b = q;
        end else begin
          a = q;
          b = p;
        end
        if (e == EDGE_TOP || e == EDGE_BOTTOM) begin
          pt.x = 16'(along_edge(a.x, b.x, a.v, b.v));
          pt.y = 16'(a.y);
        end else begin
          pt.x = 16'(a.x);
          pt.y = 16'(along_edge(a.y, b.y, a.v, b.v));
        end
        pt.last = (k == n - 1);
        points_q.insert(points_q.size(), pt);
      end
    end
    north_west = ne;
    west = se;
    prev_row[col_pos] = se;
    col_pos++;
    if (col_pos >= eff) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= eff) row_pos = 0;
    end
  endtask

  // Register writes, point comparison and prediction, all on the clock edge.
  always @(posedge clk) begin
    contour_point_t exp_pt;
    grid_node_t     cur;
    if (!rst_n) begin
      points_q.delete();
      west = '{0, 0, 0};
      north_west = '{0, 0, 0};
      col_pos = 0;
      row_pos = 0;
      iso = '0;
      interp = 1'b1;
      gsize = 9'd256;
      fail_count = 0;
      points_checked = 0;
      cells_closed = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_ISOLEVEL:    iso = pwdata[15:0];
          REG_INTERPOLATE: interp = pwdata[0];
          REG_GRID_SIZE:   gsize = pwdata[8:0];
          default:         ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (points_q.size() == 0) begin
          if (fail_count < 10)
            $display("Mismatch: point (%0d, %0d) last %0d with none expected",
                     out_point_x, out_point_y, out_last_point);
          fail_count++;
        end else begin
          exp_pt = points_q.pop_front();
          points_checked++;
          if (exp_pt.x !== out_point_x || exp_pt.y !== out_point_y ||
              exp_pt.last !== out_last_point) begin
            if (fail_count < 10)
              $display("Mismatch: expected (%0d, %0d) last %0d, got (%0d, %0d) last %0d",
                       exp_pt.x, exp_pt.y, exp_pt.last,
                       out_point_x, out_point_y, out_last_point);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        cur.v = in_sample_value;
        cur.x = in_pos_x;
        cur.y = in_pos_y;
        predict_cell(cur);
      end
    end
    points_due = points_q.size();
  end

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the marching squares contour point block: small
// grids of samples under several threshold, mode and size settings, with
// random idling on both channels; checking is done by msq_point_checker.
// ----------------------------------------------------------------------------
module tb;
  import msq_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_sample_value;
  logic signed [15:0] in_pos_x;
  logic signed [15:0] in_pos_y;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_point_x;
  logic signed [15:0] out_point_y;
  logic               out_last_point;

  int fail_count;
  int points_due;
  int points_checked;
  int cells_closed;

  int tx_pct;
  int rx_pct;
  int cur_iso;
  int grid_col;
  int grid_row;
  int grid_eff;
  int samples_sent;
  int drain_cycles;

  marching_squares_contour_points_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_value(in_sample_value),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_last_point (out_last_point)
  );

  msq_point_checker u_point_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_value(in_sample_value),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_last_point (out_last_point),
    .fail_count     (fail_count),
    .points_due     (points_due),
    .points_checked (points_checked),
    .cells_closed   (cells_closed)
  );

  // Clock with a 10 unit period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls at random at the current rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_pct);
  end

  // Hard limit on run time.
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // One register write: setup cycle, then access cycle.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Grid size as the block applies it, kept for raster tracking.
  task automatic write_grid_size(input int size);
    write_reg(REG_GRID_SIZE, 32'(size));
    grid_eff = (size < 2) ? 2 : (size > 256) ? 256 : size;
  endtask

  task automatic write_iso(input int lvl);
    cur_iso = lvl;
    write_reg(REG_ISOLEVEL, 32'(lvl));
  endtask

  // Wait until every predicted point has come out.
  task automatic wait_points_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (points_due != 0);
  endtask

  // Idle before a register write: drained, then the block's own latency.
  task automatic settle();
    wait_points_done();
    repeat (120) @(posedge clk);
  endtask

  // Offer one item, with random gaps before it, and wait for acceptance.
  task automatic send_sample(input int v, input int x, input int y);
    while ($urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_sample_value <= 16'(v);
    in_pos_x        <= 16'(x);
    in_pos_y        <= 16'(y);
    do @(posedge clk); while (in_stall);
    samples_sent++;
    grid_col++;
    if (grid_col >= grid_eff) begin
      grid_col = 0;
      grid_row++;
      if (grid_row >= grid_eff) grid_row = 0;
    end
  endtask

  // Random sample: half of them close to the threshold so that edges get crossed.
  task automatic send_random();
    int v;
    int x;
    int y;
    case ($urandom_range(0, 3))
      0, 1: begin
        v = cur_iso + $urandom_range(0, 1023) - 512;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
      end
      2:       v = $urandom_range(0, 65535);
      default: v = $urandom_range(0, 1) ? 32767 : -32768;
    endcase
    if ($urandom_range(0, 4) == 0) begin
      x = $urandom_range(0, 65535);
      y = $urandom_range(0, 65535);
    end else begin
      x = grid_col * 256 + $urandom_range(0, 63);
      y = grid_row * 256 + $urandom_range(0, 63);
    end
    send_sample(v, x, y);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_sample_value = '0;
    in_pos_x = '0;
    in_pos_y = '0;
    out_stall = 1'b0;
    tx_pct = 22;
    rx_pct = 77;
    cur_iso = 0;
    grid_col = 0;
    grid_row = 0;
    grid_eff = 256;
    samples_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a 4x4 checkerboard makes every cell a saddle, with extreme
    // values, values right at the threshold and extreme positions.
    write_iso(0);
    write_reg(REG_INTERPOLATE, 32'd1);
    write_grid_size(4);
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        send_sample(((r + c) % 2 == 0) ? ((c == 1) ? 0 : 32767)
                                       : ((c == 2) ? -1 : -32768),
                    (c == 0) ? -32768 : (c == 3) ? 32767 : c * 100,
                    (r == 0) ? -32768 : (r == 3) ? 32767 : r * 100);
      end
    end
    settle();

    // Interpolation on small grids, with a full drain halfway.
    write_iso($urandom_range(0, 1023) - 512);
    write_grid_size($urandom_range(2, 8));
    repeat (75) send_random();
    wait_points_done();
    repeat (75) send_random();
    settle();

    // Midpoint mode on the smallest grid, then both threshold extremes.
    tx_pct = 77;
    rx_pct = 22;
    write_reg(REG_INTERPOLATE, 32'd0);
    write_iso($urandom_range(0, 1023) - 512);
    write_grid_size(0);
    repeat (100) send_random();
    settle();
    write_iso(-32768);
    repeat (10) send_random();
    settle();
    write_iso(32767);
    repeat (10) send_random();
    settle();

    // No idling: oversized grid, then shrunk in the middle of a row.
    tx_pct = 0;
    rx_pct = 0;
    write_reg(REG_INTERPOLATE, 32'd1);
    write_iso($urandom_range(0, 2047) - 1024);
    while (grid_col != 0 || grid_row != 0) send_random();
    settle();
    write_grid_size(511);
    repeat (12) send_random();
    settle();
    write_grid_size(6);
    repeat (150) send_random();
    in_valid <= 1'b0;

    // Drain, then allow for the block's latency.
    drain_cycles = 0;
    while (points_due != 0 && drain_cycles < 100000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (200) @(posedge clk);

    $display("Sent %0d samples; %0d cells crossed the contour, %0d points checked.",
             samples_sent, cells_closed, points_checked);
    $display("Settings covered: both modes, threshold extremes, grid sizes 0 to 511.");
    if (fail_count == 0 && points_due == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
